@@ rtl/meest_pkg.sv @@
// package for the mobile manipulator euler step block
// types, constants and polynomial helpers shared by the controller and datapath
package meest_pkg;

  localparam int NUM_JOINTS = 7;
  localparam int JOINT_SLOTS = 7;
  localparam int VEL_W = 16;
  localparam int ST_W = 32;
  localparam int TS_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HOLONOMIC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'd1;

  localparam logic signed [31:0] TURN_K = 32'sd683565276;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [31:0] SC1 = 32'd1686629713;
  localparam logic [31:0] SC3 = 32'd693598668;
  localparam logic [31:0] SC5 = 32'd85569306;
  localparam logic [31:0] SC7 = 32'd5026995;
  localparam logic [31:0] SC9 = 32'd172272;

  // sine/cosine polynomial steps
  localparam int POLY_STEPS = 4;
  localparam int STEP_W = 3;

  typedef struct packed {
    logic signed [VEL_W-1:0] base_vx;
    logic signed [VEL_W-1:0] base_vy;
    logic signed [VEL_W-1:0] yaw_rate;
    logic signed [JOINT_SLOTS-1:0][VEL_W-1:0] joint_rate;
  } cmd_t;

  typedef struct packed {
    logic signed [ST_W-1:0] pos_x;
    logic signed [ST_W-1:0] pos_y;
    logic signed [ST_W-1:0] heading_out;
    logic signed [JOINT_SLOTS-1:0][ST_W-1:0] joint_pos;
  } state_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture command, start phase multiply
    logic phase;     // compute phase and quadrant arguments
    logic poly;      // one polynomial step
    logic first;     // first polynomial step
    logic finish;    // final quarter-wave product
    logic rotate;    // body to world rotation
    logic scale;     // multiply by time step
    logic commit;    // round, saturate, update state
  } dp_cmd_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PHASE  = 8'b0000_0010,
    S_POLY   = 8'b0000_0100,
    S_FINISH = 8'b0000_1000,
    S_ROT    = 8'b0001_0000,
    S_SCALE  = 8'b0010_0000,
    S_COMMIT = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  // saturating add of a delta to a Q16.16 state value
  function automatic logic signed [ST_W-1:0] sat_add(input logic signed [ST_W-1:0] a,
                                                      input logic signed [63:0] d);
    logic signed [64:0] s;
    s = 65'(a) + 65'(d);
    if (s > 65'sd2147483647) return 32'sh7fffffff;
    else if (s < -65'sd2147483648) return 32'sh80000000;
    else return s[31:0];
  endfunction

endpackage

@@ rtl/meest_if.sv @@
// valid/ready channel interface with payload type
// depends on meest_pkg for payload types
interface meest_cmd_if import meest_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface meest_res_if import meest_pkg::*; ();
  logic valid;
  logic ready;
  state_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/mobile_manipulator_euler_step_top.sv @@
// Euler step integrator for a mobile base and seven joints. Before its result
// can transfer, each command passes through one phase multiply, four polynomial
// steps of the shared sine/cosine evaluator, the quarter-wave product, rotation,
// time scaling and the saturating state update. The next command can transfer
// in the same cycle as that result. The result is held in the state registers;
// while it waits, the next command runs up to its state update and stalls there.
// depends on meest_pkg, meest_if, meest_ctrl, meest_dp
module mobile_manipulator_euler_step_top import meest_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  meest_cmd_if.sink             in_ch,
  meest_res_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic holo_r;
  logic [TS_W-1:0] ts_r;
  dp_cmd_t cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holo_r <= 1'b1;
      ts_r <= 16'd655;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLONOMIC: holo_r <= cfg_data[0];
        REG_TIME_STEP: ts_r <= cfg_data;
        default: ;
      endcase
    end
  end

  meest_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd
  );

  meest_dp u_dp (
    .clk, .rst_n, .cmd,
    .in_data(in_ch.data),
    .holonomic_mode(holo_r),
    .time_step(ts_r),
    .out_data(out_ch.data)
  );

endmodule

@@ rtl/meest_ctrl.sv @@
// controller state machine of the euler step block
// depends on meest_pkg for state and command types
module meest_ctrl import meest_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;

  // ready when idle; a waiting result only holds back the state update
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: begin
        cmd.phase = 1'b1;
        step_nxt = '0;
        state_nxt = S_POLY;
      end
      S_POLY: begin
        cmd.poly = 1'b1;
        cmd.first = (step_r == '0);
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(POLY_STEPS - 1)) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.rotate = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // only one datapath command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.phase, cmd.poly, cmd.finish, cmd.rotate, cmd.scale, cmd.commit}))
    else $error("multiple datapath commands");
  // a commit always raises the result valid
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result");
  // a load is followed by the phase step
  a_load_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.phase)
    else $error("phase step missing");

endmodule

@@ rtl/meest_dp.sv @@
// datapath: phase, sine/cosine polynomial, rotation, time scaling, state update
// depends on meest_pkg; driven by meest_ctrl commands
module meest_dp import meest_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  cmd_t                  in_data,
  input  logic                  holonomic_mode,
  input  logic [TS_W-1:0]       time_step,
  output state_out_t            out_data
);

  cmd_t c_r;
  logic signed [ST_W-1:0] bx_r, by_r, hd_r;
  logic signed [ST_W-1:0] ja_r [JOINT_SLOTS];
  logic signed [63:0] prod_r;
  logic [1:0] q_r;
  logic [30:0] xs_r, xc_r;          // quarter-wave arguments for sin, cos
  logic [31:0] x2s_r, x2c_r;
  logic [31:0] ts_r, tc_r;
  logic [2:0] k_r;
  logic signed [31:0] sn_r, cs_r;
  logic signed [63:0] vwx_r, vwy_r;
  logic signed [63:0] dx_r, dy_r;
  logic signed [31:0] dh_r;
  logic signed [31:0] dj_r [JOINT_SLOTS];

  logic [31:0] pc, p_sin, p_cos;
  logic [30:0] as, ac;
  logic [31:0] coef;
  logic [63:0] ms, mc, fs, fc;
  logic [31:0] ss, sc;
  logic signed [31:0] vy_eff;

  // phase and quadrant arguments
  assign p_sin = prod_r[47:16];
  assign pc = p_sin + 32'h4000_0000;
  assign as = p_sin[30] ? (ONE_Q30 - {1'b0, p_sin[29:0]}) : {1'b0, p_sin[29:0]};
  assign ac = pc[30] ? (ONE_Q30 - {1'b0, pc[29:0]}) : {1'b0, pc[29:0]};
  assign p_cos = pc;

  // polynomial coefficient for the current step
  always_comb begin
    case (k_r)
      3'd0: coef = SC7;
      3'd1: coef = SC5;
      3'd2: coef = SC3;
      default: coef = SC1;
    endcase
  end

  assign ms = 64'(ts_r) * 64'(x2s_r);
  assign mc = 64'(tc_r) * 64'(x2c_r);
  assign fs = 64'(ts_r) * 64'(xs_r);
  assign fc = 64'(tc_r) * 64'(xc_r);
  assign ss = (fs[61:30] > 32'(ONE_Q30)) ? 32'(ONE_Q30) : fs[61:30];
  assign sc = (fc[61:30] > 32'(ONE_Q30)) ? 32'(ONE_Q30) : fc[61:30];
  assign vy_eff = holonomic_mode ? 32'(c_r.base_vy) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bx_r <= '0;
      by_r <= '0;
      hd_r <= '0;
      for (int j = 0; j < JOINT_SLOTS; j++) ja_r[j] <= '0;
    end else if (cmd.commit) begin
      bx_r <= sat_add(bx_r, 64'(dx_r + (64'sd1 <<< 41)) >>> 42);
      by_r <= sat_add(by_r, 64'(dy_r + (64'sd1 <<< 41)) >>> 42);
      hd_r <= sat_add(hd_r, 64'(dh_r));
      for (int j = 0; j < JOINT_SLOTS; j++)
        ja_r[j] <= (j < NUM_JOINTS) ? sat_add(ja_r[j], 64'(dj_r[j])) : '0;
    end
  end

  // arithmetic pipeline, sequenced by the controller
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r <= in_data;
      prod_r <= 64'(hd_r) * 64'(TURN_K);
    end
    if (cmd.phase) begin
      q_r <= {p_sin[31], p_sin[30]};
      xs_r <= as;
      xc_r <= ac;
      x2s_r <= 32'((64'(as) * 64'(as)) >> 30);
      x2c_r <= 32'((64'(ac) * 64'(ac)) >> 30);
      ts_r <= SC9;
      tc_r <= SC9;
      k_r <= '0;
    end
    if (cmd.poly) begin
      ts_r <= coef - ms[61:30];
      tc_r <= coef - mc[61:30];
      k_r <= k_r + 1'b1;
    end
    // cosine sign comes from the phase shifted by a quarter turn
    if (cmd.finish) begin
      sn_r <= q_r[1] ? -$signed(ss) : $signed(ss);
      cs_r <= p_cos[31] ? -$signed(sc) : $signed(sc);
    end
    if (cmd.rotate) begin
      vwx_r <= 64'(c_r.base_vx) * 64'(cs_r) - 64'(vy_eff) * 64'(sn_r);
      vwy_r <= 64'(c_r.base_vx) * 64'(sn_r) + 64'(vy_eff) * 64'(cs_r);
    end
    if (cmd.scale) begin
      dx_r <= vwx_r * $signed({1'b0, time_step});
      dy_r <= vwy_r * $signed({1'b0, time_step});
      dh_r <= 32'((64'(c_r.yaw_rate) * $signed({1'b0, time_step}) + 64'sd2048) >>> 12);
      for (int j = 0; j < JOINT_SLOTS; j++)
        dj_r[j] <= 32'((64'($signed(c_r.joint_rate[j])) * $signed({1'b0, time_step})
                        + 64'sd2048) >>> 12);
    end
  end

  // output mapping
  always_comb begin
    out_data.pos_x = bx_r;
    out_data.pos_y = by_r;
    out_data.heading_out = hd_r;
    for (int j = 0; j < JOINT_SLOTS; j++) out_data.joint_pos[j] = ja_r[j];
  end

  // the quadrant register holds the top two phase bits
  a_arg_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.phase |=> (q_r == $past(p_sin[31:30])))
    else $error("quadrant capture");
  a_sin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (sn_r <= 32'sd1073741824 && sn_r >= -32'sd1073741824))
    else $error("sine out of range");
  a_cos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (cs_r <= 32'sd1073741824 && cs_r >= -32'sd1073741824))
    else $error("cosine out of range");

endmodule

@@ bench/meest_tb_if.sv @@
// note: the channel interfaces come with the rtl (rtl/meest_if.sv)
// this file only holds the bench clock period shared by the bench modules
// depends on nothing
package meest_tb_cfg;
  localparam int CLK_HALF = 6;
endpackage

@@ bench/testbench.sv @@
// bench for the mobile manipulator euler step block: a directed table, then
// extreme non-holonomic commands and random bursts, each checked against an euler predictor
// depends on meest_pkg, meest_tb_cfg, meest_if and the top level rtl
module testbench;
  import meest_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;
  localparam int N_RAND = 700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  meest_cmd_if in_ch ();
  meest_res_if out_ch ();

  mobile_manipulator_euler_step_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #(meest_tb_cfg::CLK_HALF) clk = 1'b1;
    #(meest_tb_cfg::CLK_HALF) clk = 1'b0;
  end

  // predictor state and configuration
  logic mdl_holo;
  logic [15:0] mdl_dt;
  logic signed [31:0] mdl_x, mdl_y, mdl_hd;
  logic signed [31:0] mdl_jnt [JOINT_SLOTS];
  state_out_t pending_states [$];
  int errors = 0;
  int cycles = 0;
  logic stall_en = 1'b0;

  // saturate a wide sum into q16.16
  function automatic logic signed [31:0] clamp32(input logic signed [31:0] a,
                                                 input logic signed [63:0] d);
    logic signed [65:0] s;
    s = 66'(a) + 66'(d);
    if (s > 66'sd2147483647) return 32'sh7fffffff;
    if (s < -66'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // polynomial quarter-wave sine, q0.30 in, clamped to one
  function automatic longint unsigned qwave(input longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = 64'd172272;
    t = 64'd5026995 - ((t * x2) >> 30);
    t = 64'd85569306 - ((t * x2) >> 30);
    t = 64'd693598668 - ((t * x2) >> 30);
    t = 64'd1686629713 - ((t * x2) >> 30);
    t = (t * x) >> 30;
    if (t > 64'd1073741824) t = 64'd1073741824;
    return t;
  endfunction

  // signed sine of a turn phase
  function automatic longint turn_sine(input logic [31:0] p);
    longint unsigned r;
    longint s;
    r = {34'd0, p[29:0]};
    s = p[30] ? longint'(qwave(64'd1073741824 - r)) : longint'(qwave(r));
    return p[31] ? -s : s;
  endfunction

  // round half up of v / 2^k, arithmetic shift is a floor
  function automatic longint round_sh(input logic signed [79:0] v, input int k);
    logic signed [79:0] t;
    t = (v + (80'sd1 <<< (k - 1))) >>> k;
    return longint'(t[63:0]);
  endfunction

  // one euler step of the pose and joints
  function automatic state_out_t euler_step(input cmd_t c);
    state_out_t r;
    longint vx, vy, wz, sn, cs, vwx, vwy;
    logic signed [63:0] prod;
    logic [31:0] ph;
    vx = longint'(c.base_vx);
    vy = mdl_holo ? longint'(c.base_vy) : 0;
    wz = longint'(c.yaw_rate);
    prod = 64'(mdl_hd) * 64'sd683565276;
    ph = prod[47:16];
    sn = turn_sine(ph);
    cs = turn_sine(ph + 32'h4000_0000);
    vwx = vx * cs - vy * sn;
    vwy = vx * sn + vy * cs;
    for (int k = 0; k < JOINT_SLOTS; k++) begin
      if (k < NUM_JOINTS)
        mdl_jnt[k] = clamp32(mdl_jnt[k],
          round_sh(80'(signed'(c.joint_rate[k])) * 80'(mdl_dt), 12));
    end
    mdl_x = clamp32(mdl_x, round_sh(80'(vwx) * 80'(mdl_dt), 42));
    mdl_y = clamp32(mdl_y, round_sh(80'(vwy) * 80'(mdl_dt), 42));
    mdl_hd = clamp32(mdl_hd, round_sh(80'(wz) * 80'(mdl_dt), 12));
    r.pos_x = mdl_x;
    r.pos_y = mdl_y;
    r.heading_out = mdl_hd;
    for (int k = 0; k < JOINT_SLOTS; k++) r.joint_pos[k] = (k < NUM_JOINTS) ? mdl_jnt[k] : '0;
    return r;
  endfunction

  // result check and receiver stall pattern
  always @(posedge clk) begin
    state_out_t want;
    cycles <= cycles + 1;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_states.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_ch.data);
        errors++;
      end else begin
        want = pending_states.pop_front();
        if (want.pos_x !== out_ch.data.pos_x) begin
          $display("%0t pos_x exp %h got %h", $time, want.pos_x, out_ch.data.pos_x);
          errors++;
        end
        if (want.pos_y !== out_ch.data.pos_y) begin
          $display("%0t pos_y exp %h got %h", $time, want.pos_y, out_ch.data.pos_y);
          errors++;
        end
        if (want.heading_out !== out_ch.data.heading_out) begin
          $display("%0t heading exp %h got %h", $time, want.heading_out,
                   out_ch.data.heading_out);
          errors++;
        end
        for (int k = 0; k < JOINT_SLOTS; k++)
          if (want.joint_pos[k] !== out_ch.data.joint_pos[k]) begin
            $display("%0t joint %0d exp %h got %h", $time, k, want.joint_pos[k],
                     out_ch.data.joint_pos[k]);
            errors++;
          end
      end
    end
    out_ch.ready <= !rst_n ? 1'b0 : (stall_en ? (($urandom_range(0, 7) > 2) ||
                    (cycles % 41 > 30)) : 1'b1);
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // register write while idle
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HOLONOMIC) mdl_holo = val[0];
    else mdl_dt = val;
  endtask

  // drive one command and record its expected state
  task automatic send_cmd(input cmd_t c, input bit has_known, input state_out_t known);
    state_out_t r;
    in_ch.valid <= 1'b1;
    in_ch.data <= c;
    do @(posedge clk); while (!in_ch.ready);
    r = euler_step(c);
    if (has_known && r !== known) begin
      $display("%0t predictor exp %h got %h", $time, known, r);
      errors++;
    end
    pending_states.push_back(r);
  endtask

  task automatic drain();
    while (pending_states.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic cmd_t rand_cmd(input int mode);
    cmd_t c;
    c = cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if (mode == 1) begin
      c.base_vx = 16'(c.base_vx >>> $urandom_range(0, 8));
      c.yaw_rate = 16'(c.yaw_rate >>> $urandom_range(0, 10));
    end
    return c;
  endfunction

  typedef struct {
    cmd_t c;
    bit has_known;
    state_out_t known;
  } dir_row_t;

  // directed table, extreme non-holonomic commands, then random phases under different settings
  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    cmd_t c;
    state_out_t z;
    int burst;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    mdl_holo = 1'b1;
    mdl_dt = 16'd655;
    mdl_x = '0; mdl_y = '0; mdl_hd = '0;
    foreach (mdl_jnt[k]) mdl_jnt[k] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero command after reset leaves the state at zero
    z = '0;
    row.c = '0; row.has_known = 1; row.known = z; rows.push_back(row);
    // unit yaw rate at the reset step turns the heading by 655
    row.c = '0; row.c.yaw_rate = 16'sd4096; row.has_known = 0; rows.push_back(row);
    row.c = '0; row.c.base_vx = 16'sh7fff; row.c.base_vy = 16'sh8000;
    row.has_known = 0; rows.push_back(row);
    row.c = '0; row.c.base_vx = 16'sh8000; row.c.base_vy = 16'sh7fff;
    row.c.yaw_rate = 16'sh8000; rows.push_back(row);
    for (int k = 0; k < JOINT_SLOTS; k++) row.c.joint_rate[k] = (k % 2) ? 16'sh8000 : 16'sh7fff;
    rows.push_back(row);
    row.c = '1; rows.push_back(row);
    foreach (rows[i]) send_cmd(rows[i].c, rows[i].has_known, rows[i].known);
    in_ch.valid <= 1'b0;
    drain();

    // non-holonomic with the largest step and extreme rates
    reg_write(REG_HOLONOMIC, 16'd0);
    reg_write(REG_TIME_STEP, 16'hffff);
    for (int i = 0; i < 12; i++) begin
      c = '0;
      c.base_vx = (i < 6) ? 16'sh7fff : 16'sh8000;
      c.base_vy = 16'sh7fff;
      c.yaw_rate = (i % 3 == 0) ? 16'sh7fff : 16'sh8000;
      for (int k = 0; k < JOINT_SLOTS; k++) c.joint_rate[k] = (i < 6) ? 16'sh7fff : 16'sh8000;
      send_cmd(c, 0, z);
    end
    in_ch.valid <= 1'b0;
    drain();

    // random phases, each with its own step and mode
    stall_en = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      reg_write(REG_HOLONOMIC, 16'(ph % 2));
      case (ph)
        0: reg_write(REG_TIME_STEP, 16'd1);
        1: reg_write(REG_TIME_STEP, 16'd0);
        2: reg_write(REG_TIME_STEP, 16'hffff);
        default: reg_write(REG_TIME_STEP, 16'($urandom_range(1, 65535)));
      endcase
      for (int n = 0; n < N_RAND / 5; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++, n++) send_cmd(rand_cmd($urandom_range(0, 1)), 0, z);
        if ($urandom_range(0, 3) != 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
